// ===== hdl/crs_pkg.sv =====
package crs_pkg;

    localparam int HW = 40;  // internal width of coefficients and horner sums

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         point_index;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        global_t;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] deriv_x;
        logic signed [31:0] deriv_y;
        logic signed [31:0] deriv_z;
        logic [3:0]         segment;
    } out_word_t;

    // halve with round half up, then clamp to 32 bits
    function automatic logic signed [31:0] sat_half(input logic signed [HW-1:0] v);
        logic signed [HW-1:0] r;
        begin
            r = (v + HW'(1)) >>> 1;
            if (r > HW'(64'sd2147483647)) begin
                sat_half = 32'sh7fffffff;
            end else if (r < -HW'(64'sd2147483648)) begin
                sat_half = 32'sh80000000;
            end else begin
                sat_half = r[31:0];
            end
        end
    endfunction

endpackage

// ===== hdl/crs_ram.sv =====
module crs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/crs_lane.sv =====
module crs_lane #(
    parameter int T_FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic [4:0]                 en,     // stage enables, stages 2..6
    input  logic signed [31:0]         p0,
    input  logic signed [31:0]         p1,
    input  logic signed [31:0]         p2,
    input  logic signed [31:0]         p3,
    input  logic [T_FRAC_BITS-1:0]     f,
    output logic signed [31:0]         pos,
    output logic signed [31:0]         deriv
);
    import crs_pkg::*;

    localparam int PW = HW + T_FRAC_BITS + 1;

    logic signed [HW-1:0] a0_reg, a1_reg, a2_reg, a3_reg, d0_reg, a1x2_reg;
    logic signed [HW-1:0] a2_3_reg, a3_3_reg, a3_4_reg;
    logic signed [HW-1:0] h1_reg, d1_reg, h2_reg, d2_reg, h3_reg, d3_reg;
    logic signed [HW-1:0] a0_next, a1_next, a2_next, a3_next;
    logic signed [HW-1:0] h1_next, d1_next, h2_next, d2_next, h3_next;
    logic [T_FRAC_BITS-1:0] f2_reg, f3_reg, f4_reg;
    logic signed [31:0] pos_reg, deriv_reg;
    logic signed [HW-1:0] e0, e1, e2, e3;

    // multiply by local t and floor back to coefficient scale
    function automatic logic signed [HW-1:0] mul_t(input logic signed [HW-1:0] h,
                                                   input logic [T_FRAC_BITS-1:0] t);
        logic signed [PW-1:0] prod;
        begin
            prod  = PW'(h) * $signed({1'b0, t});
            mul_t = HW'(prod >>> T_FRAC_BITS);
        end
    endfunction

    assign e0 = HW'(p0);
    assign e1 = HW'(p1);
    assign e2 = HW'(p2);
    assign e3 = HW'(p3);

    always_comb begin
        a0_next = -e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2 + e3;
        a1_next = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
        a2_next = e2 - e0;
        a3_next = e1 <<< 1;
        h1_next = mul_t(a0_reg, f2_reg) + a1_reg;
        d1_next = mul_t(d0_reg, f2_reg) + a1x2_reg;
        h2_next = mul_t(h1_reg, f3_reg) + a2_3_reg;
        d2_next = mul_t(d1_reg, f3_reg) + a2_3_reg;
        h3_next = mul_t(h2_reg, f4_reg) + a3_4_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            a0_reg   <= a0_next;
            a1_reg   <= a1_next;
            a2_reg   <= a2_next;
            a3_reg   <= a3_next;
            d0_reg   <= (a0_next <<< 1) + a0_next;
            a1x2_reg <= a1_next <<< 1;
            f2_reg   <= f;
        end
        if (en[1]) begin
            h1_reg   <= h1_next;
            d1_reg   <= d1_next;
            a2_3_reg <= a2_reg;
            a3_3_reg <= a3_reg;
            f3_reg   <= f2_reg;
        end
        if (en[2]) begin
            h2_reg   <= h2_next;
            d2_reg   <= d2_next;
            a3_4_reg <= a3_3_reg;
            f4_reg   <= f3_reg;
        end
        if (en[3]) begin
            h3_reg <= h3_next;
            d3_reg <= d2_reg;
        end
        if (en[4]) begin
            pos_reg   <= sat_half(h3_reg);
            deriv_reg <= sat_half(d3_reg);
        end
    end

    assign pos   = pos_reg;
    assign deriv = deriv_reg;
endmodule

// ===== hdl/catmull_rom_closed_spline_eval.sv =====
// an accepted evaluate word passes the input register, the table read and the blend stages before its result word
// throughput: one word per cycle while m_ready does not stall the pipeline, loads and evaluates mixed freely
// each stage holds its word under stall and moves on when the next one frees
// reset (aresetn low, synchronous): pipeline emptied, point total back to 4
// control point table keeps its contents over reset and is undefined until loaded
module catmull_rom_closed_spline_eval #(
    parameter int MAX_POINTS  = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [4:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  crs_pkg::in_word_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output crs_pkg::out_word_t   m_data
);
    import crs_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = 16 + CW;

    // configuration
    logic [4:0]    num_points_reg;
    logic [CW-1:0] cnt;

    // stage valids, stage 0 is the input register, stage 6 the output register
    logic [6:0] v_reg, v_next;
    logic [6:0] en;

    // stage 0: input word and scaled parameter
    logic            op0_reg;
    logic [3:0]      slot0_reg;
    logic [95:0]     pt0_reg;
    logic [SW-1:0]   s0_reg;

    logic [CW-1:0]   seg0, i0, i2, i3;
    logic [CW:0]     seg_inc, i2_inc;
    logic            wr_en;

    // segment and local t travel with the word
    logic [CW-1:0]          seg_reg [1:6];
    logic [T_FRAC_BITS-1:0] f1_reg;
    logic [T_FRAC_BITS-1:0] f0;
    logic [39:0]            frac_wide;

    logic [95:0] pt_rd [4];
    logic signed [31:0] pos_c [3];
    logic signed [31:0] der_c [3];

    // count clamped to the legal range
    always_comb begin
        if (9'(num_points_reg) < 9'd4) begin
            cnt = CW'(4);
        end else if (9'(num_points_reg) > 9'(MAX_POINTS)) begin
            cnt = CW'(MAX_POINTS);
        end else begin
            cnt = CW'(num_points_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= 5'd4;
        end else if (cfg_we) begin
            num_points_reg <= cfg_wdata;
        end
    end

    // handshake: a stage moves when it is empty or the one after it moves
    always_comb begin
        en[6] = !v_reg[6] || m_ready;
        for (int k = 5; k >= 0; k--) begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end
    assign s_ready = en[0];

    always_comb begin
        v_next = v_reg;
        if (en[0]) v_next[0] = s_valid;
        // loads end at the table write, only evaluates go on
        if (en[1]) v_next[1] = v_reg[0] && (op0_reg == OP_EVAL);
        for (int k = 2; k <= 6; k++) begin
            if (en[k]) v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    // stage 0 capture: global t times count
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            op0_reg   <= s_data.opcode;
            slot0_reg <= s_data.point_index;
            pt0_reg   <= {s_data.coord_x, s_data.coord_y, s_data.coord_z};
            s0_reg    <= SW'(s_data.global_t) * SW'(cnt);
        end
    end

    // neighbor indices modulo the count
    always_comb begin
        seg0    = s0_reg[SW-1:16];
        seg_inc = (CW+1)'(seg0) + (CW+1)'(1);
        i0      = (seg0 == '0) ? cnt - CW'(1) : seg0 - CW'(1);
        i2      = (seg_inc == (CW+1)'(cnt)) ? '0 : seg_inc[CW-1:0];
        i2_inc  = (CW+1)'(i2) + (CW+1)'(1);
        i3      = (i2_inc == (CW+1)'(cnt)) ? '0 : i2_inc[CW-1:0];
    end

    // local t with T_FRAC_BITS fraction bits
    assign frac_wide = {s0_reg[15:0], 24'd0};
    assign f0        = frac_wide[39 -: T_FRAC_BITS];

    // the table write happens in program order with the reads of stage 0
    assign wr_en = v_reg[0] && (op0_reg == OP_LOAD) && en[1]
                   && (9'(slot0_reg) < 9'(MAX_POINTS));

    // four copies of the table, one per neighbor, written together
    crs_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ram0 (
        .aclk(aclk), .we(wr_en), .waddr(AW'(slot0_reg)), .wdata(pt0_reg),
        .re(en[1]), .raddr(AW'(i0)), .rdata(pt_rd[0]));
    crs_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ram1 (
        .aclk(aclk), .we(wr_en), .waddr(AW'(slot0_reg)), .wdata(pt0_reg),
        .re(en[1]), .raddr(AW'(seg0)), .rdata(pt_rd[1]));
    crs_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ram2 (
        .aclk(aclk), .we(wr_en), .waddr(AW'(slot0_reg)), .wdata(pt0_reg),
        .re(en[1]), .raddr(AW'(i2)), .rdata(pt_rd[2]));
    crs_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_ram3 (
        .aclk(aclk), .we(wr_en), .waddr(AW'(slot0_reg)), .wdata(pt0_reg),
        .re(en[1]), .raddr(AW'(i3)), .rdata(pt_rd[3]));

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            seg_reg[1] <= seg0;
            f1_reg     <= f0;
        end
        for (int k = 2; k <= 6; k++) begin
            if (en[k]) seg_reg[k] <= seg_reg[k-1];
        end
    end

    // one blending lane per axis, x in the top third of a table word
    for (genvar c = 0; c < 3; c++) begin : g_lane
        crs_lane #(.T_FRAC_BITS(T_FRAC_BITS)) u_lane (
            .aclk (aclk),
            .en   (en[6:2]),
            .p0   ($signed(pt_rd[0][95-32*c -: 32])),
            .p1   ($signed(pt_rd[1][95-32*c -: 32])),
            .p2   ($signed(pt_rd[2][95-32*c -: 32])),
            .p3   ($signed(pt_rd[3][95-32*c -: 32])),
            .f    (f1_reg),
            .pos  (pos_c[c]),
            .deriv(der_c[c])
        );
    end

    assign m_valid         = v_reg[6];
    assign m_data.pos_x    = pos_c[0];
    assign m_data.pos_y    = pos_c[1];
    assign m_data.pos_z    = pos_c[2];
    assign m_data.deriv_x  = der_c[0];
    assign m_data.deriv_y  = der_c[1];
    assign m_data.deriv_z  = der_c[2];
    assign m_data.segment  = 4'(seg_reg[6]);

    // a load never goes past the table write
    a_load_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[0] && op0_reg == OP_LOAD && en[1]) |=> !v_reg[1])
        else $error("load word entered blend stages");

    // segment chosen always lies inside the curve
    a_seg_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[1] |-> (seg_reg[1] < cnt))
        else $error("segment outside point count");

    // a held stage with a blocked successor keeps its valid
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[3] && !en[3]) |=> v_reg[3])
        else $error("stalled word dropped");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule
